// ===== rtl/ecf_pkg.sv =====
// Shared types, widths and constants of the ERB-rate center frequency generator.
// Holds the fixed-point constants and the elaboration-time function for the roots 2^(2^-k).
// No dependencies.
package ecf_pkg;

    localparam int HZ_W      = 15;   // whole hertz
    localparam int CNT_W     = 9;    // channel count
    localparam int IDX_W     = 8;    // channel index
    localparam int DIV_W     = 9;    // channel count minus one
    localparam int ERB_W     = 22;   // ERB rate, Q6.16
    localparam int QI_W      = ERB_W + IDX_W;
    localparam int FREQ_W    = 19;
    localparam int LOG_BITS  = 20;
    localparam int P_W       = 31;   // Q30 in [1,2)
    localparam int T_W       = 32;   // exponent, Q28
    localparam int NSH_W     = 3;    // clamped integer part of the exponent
    localparam int ADDR_W    = 2;

    localparam int OUT_FRAC_BITS_DEF = 4;

    localparam logic [ADDR_W-1:0] REG_LOW   = 2'd0;
    localparam logic [ADDR_W-1:0] REG_HIGH  = 2'd1;
    localparam logic [ADDR_W-1:0] REG_COUNT = 2'd2;

    localparam logic [HZ_W-1:0]  LOW_RST   = 15'd50;
    localparam logic [HZ_W-1:0]  HIGH_RST  = 15'd8000;
    localparam logic [CNT_W-1:0] COUNT_RST = 9'd64;

    localparam logic [24:0] C_SLOPE_Q32 = 25'd18769007;
    localparam logic [26:0] K_Q24       = 27'd108079529;
    localparam logic [29:0] IK_Q32      = 30'd666708997;
    localparam logic [23:0] INV_Q16     = 24'd14996796;
    localparam logic [P_W-1:0] ONE_Q30  = 31'h4000_0000;
    localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

    typedef struct packed {
        logic              busy;
        logic [HZ_W-1:0]   low_hz;
        logic [CNT_W-1:0]  count;
        logic [DIV_W-1:0]  div;
        logic [ERB_W-1:0]  erb_low;
        logic [ERB_W-1:0]  quo;
        logic [DIV_W-1:0]  rem;
        logic              neg;
    } t_setup;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             oor;
        logic             single;
    } t_tag;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] val;
        logic [63:0] res;
        logic [63:0] bitv;
        val  = v;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (val >= res + bitv) begin
                val = val - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 2^(2^-k) in Q30, by repeated square roots from 2.0, as the cells need it
    function automatic logic [P_W-1:0] pow_root(input int k);
        logic [63:0] root;
        root = 64'd1 << 31;
        for (int j = 1; j <= k; j++) begin
            root = isqrt64(root << 30);
        end
        return root[P_W-1:0];
    endfunction

endpackage

// ===== rtl/ecf_setup.sv =====
// Configuration registers and the setup sequencer: ERB rates of the band edges
// and the quotient and remainder of their spacing by the channel count minus one.
// Depends on ecf_pkg.
module ecf_setup (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ecf_pkg::ADDR_W-1:0] i_cfg_addr,
    input  logic [ecf_pkg::HZ_W-1:0]   i_cfg_wdata,
    output ecf_pkg::t_setup            o_setup
);
    import ecf_pkg::*;

    typedef enum logic [2:0] {S_INIT, S_SQ, S_FIN, S_DIFF, S_DIV, S_IDLE} t_state;

    localparam int ITER_W = $clog2(ERB_W);
    localparam logic [ITER_W-1:0] SQ_LAST  = ITER_W'(LOG_BITS - 1);
    localparam logic [ITER_W-1:0] DIV_LAST = ITER_W'(ERB_W - 1);
    localparam logic [49:0] ROUND = 50'd1 << 27;

    t_state             r_state;
    logic               r_sel;
    logic [HZ_W-1:0]    r_low;
    logic [HZ_W-1:0]    r_high;
    logic [CNT_W-1:0]   r_count;
    logic [P_W-1:0]     r_m;
    logic [ERB_W:0]     r_l;
    logic [ITER_W-1:0]  r_iter;
    logic [ERB_W-1:0]   r_elo;
    logic [ERB_W-1:0]   r_ehi;
    logic [ERB_W-1:0]   r_quo;
    logic [DIV_W-1:0]   r_rem;
    logic               r_neg;

    logic [HZ_W-1:0]    hz;
    logic [39:0]        x;
    logic [39:0]        xs;
    logic [2:0]         lead;
    logic [61:0]        sq;
    logic [49:0]        lk;
    logic [ERB_W:0]     diff;
    logic [DIV_W-1:0]   div;
    logic [DIV_W:0]     trial;
    logic               qbit;

    always_comb begin
        hz   = r_sel ? r_high : r_low;
        x    = 40'(hz) * 40'(C_SLOPE_Q32) + (40'd1 << 32);
        lead = '0;
        for (int b = 0; b < 8; b++) begin
            if (x[32 + b]) begin
                lead = 3'(b);
            end
        end
        xs    = x >> (6'(lead) + 6'd2);
        sq    = 62'(r_m) * 62'(r_m);
        lk    = 50'(r_l) * 50'(K_Q24) + ROUND;
        diff  = {1'b0, r_ehi} - {1'b0, r_elo};
        div   = DIV_W'(r_count - 9'd1);
        trial = {r_rem, r_quo[ERB_W-1]};
        qbit  = trial >= {1'b0, div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_sel   <= 1'b0;
            r_low   <= LOW_RST;
            r_high  <= HIGH_RST;
            r_count <= COUNT_RST;
        end else if (i_cfg_we) begin
            // any write restarts the coefficient run
            r_state <= S_INIT;
            r_sel   <= 1'b0;
            unique case (i_cfg_addr)
                REG_LOW:   r_low   <= i_cfg_wdata;
                REG_HIGH:  r_high  <= i_cfg_wdata;
                REG_COUNT: r_count <= i_cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end else begin
            unique case (r_state)
                S_INIT: begin
                    r_m     <= xs[P_W-1:0];
                    r_l     <= (ERB_W+1)'(lead);
                    r_iter  <= '0;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    if (sq[61]) begin
                        r_m <= sq[61:31];
                        r_l <= {r_l[ERB_W-1:0], 1'b1};
                    end else begin
                        r_m <= sq[60:30];
                        r_l <= {r_l[ERB_W-1:0], 1'b0};
                    end
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == SQ_LAST) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_sel) begin
                        r_elo   <= lk[49:28];
                        r_sel   <= 1'b1;
                        r_state <= S_INIT;
                    end else begin
                        r_ehi   <= lk[49:28];
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_neg   <= diff[ERB_W];
                    r_quo   <= diff[ERB_W] ? ERB_W'(-diff) : diff[ERB_W-1:0];
                    r_rem   <= '0;
                    r_iter  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= qbit ? DIV_W'(trial - {1'b0, div}) : trial[DIV_W-1:0];
                    r_quo  <= {r_quo[ERB_W-2:0], qbit};
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == DIV_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: ;
                default: r_state <= S_INIT;
            endcase
        end
    end

    assign o_setup.busy    = r_state != S_IDLE;
    assign o_setup.low_hz  = r_low;
    assign o_setup.count   = r_count;
    assign o_setup.div     = div;
    assign o_setup.erb_low = r_elo;
    assign o_setup.quo     = r_quo;
    assign o_setup.rem     = r_rem;
    assign o_setup.neg     = r_neg;

endmodule

// ===== rtl/ecf_div_cell.sv =====
// One quotient bit of the per-item remainder division (restoring step).
// Depends on ecf_pkg.
module ecf_div_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  ecf_pkg::t_tag            i_tag,
    input  logic [ecf_pkg::QI_W-1:0] i_qi,
    input  logic [ecf_pkg::DIV_W-1:0] i_rem,
    input  logic [ecf_pkg::IDX_W-1:0] i_low,
    input  logic [ecf_pkg::IDX_W-1:0] i_quo,
    input  logic [ecf_pkg::DIV_W-1:0] i_div,
    output logic                     o_valid,
    output ecf_pkg::t_tag            o_tag,
    output logic [ecf_pkg::QI_W-1:0] o_qi,
    output logic [ecf_pkg::DIV_W-1:0] o_rem,
    output logic [ecf_pkg::IDX_W-1:0] o_low,
    output logic [ecf_pkg::IDX_W-1:0] o_quo
);
    import ecf_pkg::*;

    logic             r_valid;
    t_tag             r_tag;
    logic [QI_W-1:0]  r_qi;
    logic [DIV_W-1:0] r_rem;
    logic [IDX_W-1:0] r_low;
    logic [IDX_W-1:0] r_quo;

    logic [DIV_W:0]   trial;
    logic             qbit;

    assign trial = {i_rem, i_low[IDX_W-1]};
    assign qbit  = trial >= {1'b0, i_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag <= i_tag;
            r_qi  <= i_qi;
            r_rem <= qbit ? DIV_W'(trial - {1'b0, i_div}) : trial[DIV_W-1:0];
            r_low <= {i_low[IDX_W-2:0], 1'b0};
            r_quo <= {i_quo[IDX_W-2:0], qbit};
        end
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_qi    = r_qi;
    assign o_rem   = r_rem;
    assign o_low   = r_low;
    assign o_quo   = r_quo;

endmodule

// ===== rtl/ecf_pow_cell.sv =====
// One factor of 2^frac: multiplies by the root 2^(2^-K) when its exponent bit is set.
// Depends on ecf_pkg.
module ecf_pow_cell #(
    parameter int K = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  ecf_pkg::t_tag                 i_tag,
    input  logic [ecf_pkg::P_W-1:0]       i_p,
    input  logic [ecf_pkg::LOG_BITS-1:0]  i_frac,
    input  logic [ecf_pkg::NSH_W-1:0]     i_nsh,
    output logic                          o_valid,
    output ecf_pkg::t_tag                 o_tag,
    output logic [ecf_pkg::P_W-1:0]       o_p,
    output logic [ecf_pkg::LOG_BITS-1:0]  o_frac,
    output logic [ecf_pkg::NSH_W-1:0]     o_nsh
);
    import ecf_pkg::*;

    localparam logic [P_W-1:0] ROOT = pow_root(K);

    logic                r_valid;
    t_tag                r_tag;
    logic [P_W-1:0]      r_p;
    logic [LOG_BITS-1:0] r_frac;
    logic [NSH_W-1:0]    r_nsh;

    logic [2*P_W-1:0]    prod;

    assign prod = (2*P_W)'(i_p) * (2*P_W)'(ROOT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag  <= i_tag;
            r_p    <= i_frac[LOG_BITS-K] ? prod[P_W+29:30] : i_p;
            r_frac <= i_frac;
            r_nsh  <= i_nsh;
        end
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_p     = r_p;
    assign o_frac  = r_frac;
    assign o_nsh   = r_nsh;

endmodule

// ===== rtl/erb_center_frequency_gen.sv =====
// ERB-rate center frequency generator, top level.
// Depends on ecf_pkg, ecf_setup, ecf_div_cell and ecf_pow_cell.
//
// Give a channel index, get back that channel's center frequency in hertz with
// OUT_FRAC_BITS fraction bits; channels sit evenly on the ERB-rate scale between
// the low and high band edges. The block takes one index per clock while input
// stall is low and returns one result per index, in order. A stall on the output
// only holds the occupied stages: empty stages in the pipe keep filling, so input
// transfers go on until the pipe is full.
// After reset and after every configuration write the setup sequencer runs two
// log2 runs for the band edges, forms the difference and divides the spacing;
// input stall is high throughout.
// That sequencer has its own multipliers and steps one squaring a cycle.
// Per item the path is: input register (index products), eight division cells
// (one quotient bit each), channel rate, exponent multiply, twenty power cells
// (one root factor each), scaling multiply and the output register.
module erb_center_frequency_gen #(
    parameter int OUT_FRAC_BITS = ecf_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ecf_pkg::ADDR_W-1:0]  i_cfg_addr,
    input  logic [ecf_pkg::HZ_W-1:0]    i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [ecf_pkg::IDX_W-1:0]   i_channel_index,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [ecf_pkg::FREQ_W-1:0]  o_center_freq,
    output logic [ecf_pkg::IDX_W-1:0]   o_index_echo,
    output logic                        o_out_of_range
);
    import ecf_pkg::*;

    localparam int SHIFT = 46 - OUT_FRAC_BITS;
    localparam logic [63:0] HALF = 64'd1 << (SHIFT - 1);
    localparam int PS_W = P_W + 7;   // product after the integer shift
    localparam int NR_W = DIV_W + IDX_W;

    t_setup setup;

    ecf_setup u_setup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_setup     (setup)
    );

    // stage hold chain, from the output back to the input
    logic                en_o, en_f, en_t, en_e, en_0;
    logic [IDX_W:0]      en_div;
    logic [LOG_BITS:0]   en_pow;

    // input stage
    logic                r_v0;
    t_tag                r_tag0;
    logic [QI_W-1:0]     r_qi0;
    logic [NR_W-1:0]     r_nr0;
    logic                accept;
    t_tag                tag_in;

    assign accept = i_in_valid && !o_in_stall;
    assign en_0   = !r_v0 || en_div[0];
    assign o_in_stall = setup.busy || !en_0;

    always_comb begin
        tag_in.idx    = i_channel_index;
        tag_in.oor    = {1'b0, i_channel_index} >= setup.count;
        tag_in.single = setup.count == 9'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en_0) begin
            r_v0 <= accept;
        end
    end

    // trunc(D*i/M) = Q*i + floor(R*i/M), D = Q*M + R
    always_ff @(posedge i_clk) begin
        if (en_0) begin
            r_tag0 <= tag_in;
            r_qi0  <= QI_W'(setup.quo) * QI_W'(i_channel_index);
            r_nr0  <= NR_W'(setup.rem) * NR_W'(i_channel_index);
        end
    end

    // division cells
    logic [IDX_W:0]    dv;
    t_tag              dtag [IDX_W+1];
    logic [QI_W-1:0]   dqi  [IDX_W+1];
    logic [DIV_W-1:0]  drem [IDX_W+1];
    logic [IDX_W-1:0]  dlow [IDX_W+1];
    logic [IDX_W-1:0]  dquo [IDX_W+1];

    assign dv[0]   = r_v0;
    assign dtag[0] = r_tag0;
    assign dqi[0]  = r_qi0;
    assign drem[0] = r_nr0[NR_W-1:IDX_W];
    assign dlow[0] = r_nr0[IDX_W-1:0];
    assign dquo[0] = '0;
    assign en_div[IDX_W] = en_e;

    for (genvar g = 0; g < IDX_W; g++) begin : g_div
        assign en_div[g] = !dv[g+1] || en_div[g+1];
        ecf_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en_div[g]),
            .i_valid (dv[g]),
            .i_tag   (dtag[g]),
            .i_qi    (dqi[g]),
            .i_rem   (drem[g]),
            .i_low   (dlow[g]),
            .i_quo   (dquo[g]),
            .i_div   (setup.div),
            .o_valid (dv[g+1]),
            .o_tag   (dtag[g+1]),
            .o_qi    (dqi[g+1]),
            .o_rem   (drem[g+1]),
            .o_low   (dlow[g+1]),
            .o_quo   (dquo[g+1])
        );
    end

    // channel rate
    logic              r_ve;
    t_tag              r_tage;
    logic [ERB_W-1:0]  r_ec;
    logic [QI_W-1:0]   tot;
    logic [ERB_W+1:0]  ec_s;

    assign en_e = !r_ve || en_t;

    always_comb begin
        tot  = dqi[IDX_W] + QI_W'(dquo[IDX_W]);
        ec_s = setup.neg ? ({2'b00, setup.erb_low} - (ERB_W+2)'(tot[ERB_W-1:0]))
                         : ({2'b00, setup.erb_low} + (ERB_W+2)'(tot[ERB_W-1:0]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ve <= 1'b0;
        end else if (en_e) begin
            r_ve <= dv[IDX_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_e) begin
            r_tage <= dtag[IDX_W];
            r_ec   <= ec_s[ERB_W+1] ? '0 : ec_s[ERB_W-1:0];
        end
    end

    // exponent t = Ec * log2(10)/21.4, Q28
    logic                r_vt;
    t_tag                r_tagt;
    logic [LOG_BITS-1:0] r_frac;
    logic [NSH_W-1:0]    r_nsh;
    logic [ERB_W+29:0]   tprod;
    logic [T_W-1:0]      tval;

    assign en_t  = !r_vt || en_pow[0];
    assign tprod = (ERB_W+30)'(r_ec) * (ERB_W+30)'(IK_Q32);
    assign tval  = tprod[T_W+19:20];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vt <= 1'b0;
        end else if (en_t) begin
            r_vt <= r_ve;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_t) begin
            r_tagt <= r_tage;
            r_frac <= tval[27:28-LOG_BITS];
            // integer part clamps at seven
            r_nsh  <= (tval[T_W-1:28] > 4'd7) ? 3'd7 : tval[30:28];
        end
    end

    // power cells
    logic [LOG_BITS:0]   pv;
    t_tag                ptag  [LOG_BITS+1];
    logic [P_W-1:0]      pp    [LOG_BITS+1];
    logic [LOG_BITS-1:0] pfrac [LOG_BITS+1];
    logic [NSH_W-1:0]    pnsh  [LOG_BITS+1];

    assign pv[0]    = r_vt;
    assign ptag[0]  = r_tagt;
    assign pp[0]    = ONE_Q30;
    assign pfrac[0] = r_frac;
    assign pnsh[0]  = r_nsh;
    assign en_pow[LOG_BITS] = en_f;

    for (genvar g = 0; g < LOG_BITS; g++) begin : g_pow
        assign en_pow[g] = !pv[g+1] || en_pow[g+1];
        ecf_pow_cell #(
            .K (g + 1)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en_pow[g]),
            .i_valid (pv[g]),
            .i_tag   (ptag[g]),
            .i_p     (pp[g]),
            .i_frac  (pfrac[g]),
            .i_nsh   (pnsh[g]),
            .o_valid (pv[g+1]),
            .o_tag   (ptag[g+1]),
            .o_p     (pp[g+1]),
            .o_frac  (pfrac[g+1]),
            .o_nsh   (pnsh[g+1])
        );
    end

    // (2^t - 1) / 0.00437
    logic              r_vf;
    t_tag              r_tagf;
    logic              r_below;
    logic [PS_W+23:0]  r_fprod;
    logic [PS_W-1:0]   ps;

    assign en_f = !r_vf || en_o;
    assign ps   = PS_W'(pp[LOG_BITS]) << pnsh[LOG_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
        end else if (en_f) begin
            r_vf <= pv[LOG_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_f) begin
            r_tagf  <= ptag[LOG_BITS];
            r_below <= ps < PS_W'(ONE_Q30);
            r_fprod <= (PS_W+24)'(ps - PS_W'(ONE_Q30)) * (PS_W+24)'(INV_Q16);
        end
    end

    // output register: round half up, saturate, special cases
    logic               r_out_valid;
    logic [FREQ_W-1:0]  r_freq;
    logic [IDX_W-1:0]   r_idx;
    logic               r_oor;
    logic [63:0]        rnd;
    logic [63:0]        lowsh;
    logic [FREQ_W-1:0]  freq;

    assign en_o = !r_out_valid || !i_out_stall;

    always_comb begin
        rnd   = (64'(r_fprod) + HALF) >> SHIFT;
        lowsh = 64'(setup.low_hz) << OUT_FRAC_BITS;
        priority if (r_tagf.oor) begin
            freq = '0;
        end else if (r_tagf.single) begin
            freq = (lowsh > 64'(FREQ_MAX)) ? FREQ_MAX : lowsh[FREQ_W-1:0];
        end else if (r_below) begin
            freq = '0;
        end else begin
            freq = (rnd > 64'(FREQ_MAX)) ? FREQ_MAX : rnd[FREQ_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_o) begin
            r_out_valid <= r_vf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_freq <= freq;
            r_idx  <= r_tagf.idx;
            r_oor  <= r_tagf.oor;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_center_freq  = r_freq;
    assign o_index_echo   = r_idx;
    assign o_out_of_range = r_oor;

endmodule
